// ===== hw/rtl/dtti_pkg.sv =====
// Shared types and character constants for the decimal text to integer block.
// No dependencies.
package dtti_pkg;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [63:0] MAX_POS_I64 = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MUL10_LIMIT = 64'h1999_9999_9999_9999;

  // Classified character, as queued between front and back.
  typedef struct packed {
    logic       empty;
    logic       last;
    logic       is_digit;
    logic       is_plus;
    logic       is_minus;
    logic [3:0] digit;
  } item_t;

endpackage

// ===== hw/rtl/dtti_front.sv =====
// Front end: classifies each incoming character into an item_t record.
// Depends on dtti_pkg.
module dtti_front import dtti_pkg::*; (
  input  logic [7:0] ch_i,
  input  logic       last_i,
  input  logic       empty_string_i,
  output item_t      item_o
);

  always_comb begin
    item_o.empty    = empty_string_i;
    item_o.last     = last_i;
    item_o.is_digit = (ch_i >= CH_ZERO) && (ch_i <= CH_NINE);
    item_o.is_plus  = (ch_i == CH_PLUS);
    item_o.is_minus = (ch_i == CH_MINUS);
    // '0'..'9' are 0x30..0x39, so the low nibble is the digit value
    item_o.digit    = ch_i[3:0];
  end

endmodule

// ===== hw/rtl/dtti_queue.sv =====
// Small FIFO of classified characters between front and back.
// Depends on dtti_pkg.
module dtti_queue import dtti_pkg::*; #(
  parameter int Depth = 4
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t item_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] Full    = CntW'(Depth);

  item_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == Full);
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Full)
    else $error("queue count above depth");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("empty queue with pointer gap");

endmodule

// ===== hw/rtl/dtti_back.sv =====
// Back end: parse state update per character, end-of-string capture and
// output register with sign handling. Depends on dtti_pkg.
module dtti_back import dtti_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        signed_mode_i,
  input  logic        q_valid_i,
  input  item_t       q_item_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] value_o,
  output logic        failed_o
);

  localparam logic [1:0] PH_START  = 2'd0;
  localparam logic [1:0] PH_MINUS  = 2'd1;
  localparam logic [1:0] PH_PLUS   = 2'd2;
  localparam logic [1:0] PH_DIGITS = 2'd3;

  logic [1:0]  phase_q, phase_d;
  logic [63:0] acc_q, acc_d;
  logic        neg_q, neg_d;
  logic        err_q, err_d;

  // end-of-string capture
  logic        fin_v_q;
  logic [63:0] fin_acc_q;
  logic        fin_fail_q, fin_neg_q;
  logic        fin_fail_d;

  logic        out_v_q;
  logic [63:0] out_val_q;
  logic        out_fail_q;

  logic        ends, out_ready, fin_ready, out_load, fin_load;
  logic [63:0] times10;
  logic [64:0] sum;
  logic        too_big;

  assign ends      = q_item_i.empty || q_item_i.last;
  assign out_ready = !out_v_q || !out_stall_i;
  assign fin_ready = !fin_v_q || out_ready;
  assign q_pop_o   = q_valid_i && (!ends || fin_ready);
  assign fin_load  = q_pop_o && ends;
  assign out_load  = fin_v_q && out_ready;

  // acc * 10 = acc * 8 + acc * 2; only used when acc <= MUL10_LIMIT
  assign too_big = (acc_q > MUL10_LIMIT);
  assign times10 = {acc_q[60:0], 3'b000} + {acc_q[62:0], 1'b0};
  assign sum     = {1'b0, times10} + {61'd0, q_item_i.digit};

  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    neg_d   = neg_q;
    err_d   = err_q;
    if (!q_item_i.empty && !err_q) begin
      if (phase_q == PH_START && signed_mode_i && q_item_i.is_minus) begin
        neg_d   = 1'b1;
        phase_d = PH_MINUS;
      end else if ((phase_q == PH_START || phase_q == PH_MINUS) && q_item_i.is_plus) begin
        phase_d = PH_PLUS;
      end else if (q_item_i.is_digit) begin
        if (too_big || sum[64]) begin
          err_d = 1'b1;
        end else begin
          acc_d   = sum[63:0];
          phase_d = PH_DIGITS;
        end
      end else begin
        err_d = 1'b1;
      end
    end
    fin_fail_d = err_d || (phase_d != PH_DIGITS) ||
                 (signed_mode_i ? (acc_d > MAX_POS_I64) : neg_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      acc_q   <= '0;
      neg_q   <= 1'b0;
      err_q   <= 1'b0;
      fin_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (fin_load) begin
        phase_q <= PH_START;
        acc_q   <= '0;
        neg_q   <= 1'b0;
        err_q   <= 1'b0;
      end else if (q_pop_o) begin
        phase_q <= phase_d;
        acc_q   <= acc_d;
        neg_q   <= neg_d;
        err_q   <= err_d;
      end
      fin_v_q <= fin_load || (fin_v_q && !out_load);
      out_v_q <= out_load || (out_v_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_load) begin
      fin_acc_q  <= acc_d;
      fin_fail_q <= fin_fail_d;
      fin_neg_q  <= signed_mode_i && neg_d;
    end
    if (out_load) begin
      out_fail_q <= fin_fail_q;
      if (fin_fail_q) begin
        out_val_q <= '0;
      end else if (fin_neg_q) begin
        out_val_q <= 64'd0 - fin_acc_q;
      end else begin
        out_val_q <= fin_acc_q;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign value_o     = out_val_q;
  assign failed_o    = out_fail_q;

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && failed_o) |-> (value_o == '0))
    else $error("failed result with nonzero value");

  a_clear_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_load |=> (phase_q == PH_START && acc_q == '0 && !neg_q && !err_q))
    else $error("parse state not cleared after string end");

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q && !fin_load) |=> err_q)
    else $error("error latch dropped mid-string");

endmodule

// ===== hw/rtl/decimal_text_to_integer.sv =====
// Decimal text to integer: one character per transfer, result on string end.
// Result path: queue, then end-of-string capture, then output register.
// Throughput: one character per cycle while the output is not stalled; set
// by the back-end x10-and-add. Queue decouples input stall from output stall.
// Reset: asynchronous active low; clears parse state and queue, signed mode 1.
// Depends on dtti_pkg, dtti_front, dtti_queue, dtti_back.
module decimal_text_to_integer import dtti_pkg::*; #(
  parameter int QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  ch_i,
  input  logic        last_i,
  input  logic        empty_string_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] value_o,
  output logic        failed_o
);

  logic  signed_mode_q;
  item_t front_item, q_item;
  logic  q_full, q_valid, q_pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      signed_mode_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      signed_mode_q <= cfg_data_i;
    end
  end

  dtti_front u_front (
    .ch_i           (ch_i),
    .last_i         (last_i),
    .empty_string_i (empty_string_i),
    .item_o         (front_item)
  );

  dtti_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_valid_i),
    .item_i  (front_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  assign in_stall_o = q_full;

  dtti_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .signed_mode_i (signed_mode_q),
    .q_valid_i     (q_valid),
    .q_item_i      (q_item),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .value_o       (value_o),
    .failed_o      (failed_o)
  );

endmodule
